// File: rtl/sdf_pkg.sv
package sdf_pkg;

   localparam int DigitCount = 8;
   localparam int ValueWidth = 32;
   localparam int BcdWidth   = 4;
   localparam int CellCount  = 10;
   localparam int AddrWidth  = 4;
   localparam int DataWidth  = 8;
   localparam int PosWidth   = (DigitCount > 1) ? $clog2(DigitCount) : 1;
   localparam int CountWidth = $clog2(ValueWidth);
   localparam int PointBit   = 7;

   localparam logic [DataWidth-1:0] BlankReset = DataWidth'(15);
   localparam logic [DataWidth-1:0] MinusReset = DataWidth'(10);

   typedef enum logic {
      CSR_BLANK_CODE = 1'b0,
      CSR_MINUS_CODE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic clear;
      logic convert;
      logic drain;
   } cell_ctrl_type;

endpackage

// File: rtl/signed_decimal_digit_frame_formatter.sv
// Takes a signed 32-bit value on start and writes digit-register words for
// positions 1 to 8, least significant first, blanking above the top digit,
// a minus word after the first blank for negative values, and an optional
// decimal point word. The magnitude is converted one bit per cycle by a
// chain of ten BCD cells; the words then leave one per cycle, the digit
// words straight out of the low cell as the chain drains (8 to 10 words).
// A new start is taken in the cycle busy falls, while the last word is
// still showing. Each word is on the rsp_ ports for one cycle with rsp_valid
// high and must be taken then; the receiver cannot stall. csr_ready is
// always high.
module signed_decimal_digit_frame_formatter (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [sdf_pkg::ValueWidth-1:0] req_value,
   input  logic                                  req_dot_enable,
   input  logic [2:0]                            req_dot_places,
   output logic                                  rsp_valid,
   output logic [sdf_pkg::AddrWidth-1:0]         rsp_register_address,
   output logic [sdf_pkg::DataWidth-1:0]         rsp_register_data,
   output logic                                  rsp_last,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic                                  csr_index,
   input  logic [sdf_pkg::DataWidth-1:0]         csr_data
);
   import sdf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_EMIT,
      ST_MINUS,
      ST_DOT
   } state_type;

   state_type               state_ff, state_in;
   logic [ValueWidth-1:0]   shift_ff, shift_in;
   logic                    negative_ff, negative_in;
   logic                    dot_enable_ff, dot_enable_in;
   logic [2:0]              dot_places_ff, dot_places_in;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic [PosWidth-1:0]     pos_ff, pos_in;
   logic                    emit_done_ff, emit_done_in;
   logic [BcdWidth-1:0]     dot_digit_ff, dot_digit_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [AddrWidth-1:0]    rsp_addr_ff, rsp_addr_in;
   logic [DataWidth-1:0]    rsp_data_ff, rsp_data_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic [DataWidth-1:0]    blank_code_ff, blank_code_in;
   logic [DataWidth-1:0]    minus_code_ff, minus_code_in;

   cell_ctrl_type           cell_ctrl;
   logic [BcdWidth-1:0]     low_digit;
   logic                    chain_zero;
   logic                    chain_overflow;
   logic [ValueWidth-1:0]   magnitude;
   logic                    dot_on;
   logic                    blank_now;
   logic                    minus_now;
   logic                    final_pos;
   logic [DataWidth-1:0]    point_mask;

   sdf_bcd_chain u_chain (
      .clock     (clock),
      .ctrl      (cell_ctrl),
      .serial_in (shift_ff[ValueWidth-1]),
      .low_digit (low_digit),
      .all_zero  (chain_zero),
      .overflow  (chain_overflow)
   );

   assign magnitude  = req_value[ValueWidth-1] ? ValueWidth'(-req_value)
                                               : ValueWidth'(req_value);
   assign dot_on     = dot_enable_ff && (int'(dot_places_ff) < DigitCount);
   assign blank_now  = (pos_ff != '0) && chain_zero;
   assign minus_now  = blank_now && negative_ff;
   assign final_pos  = (pos_ff == PosWidth'(DigitCount - 1));
   assign point_mask = DataWidth'(1) << PointBit;

   always_comb begin
      state_in      = state_ff;
      shift_in      = shift_ff;
      negative_in   = negative_ff;
      dot_enable_in = dot_enable_ff;
      dot_places_in = dot_places_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      emit_done_in  = emit_done_ff;
      dot_digit_in  = dot_digit_ff;
      rsp_valid_in  = 1'b0;
      rsp_addr_in   = rsp_addr_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = 1'b0;
      blank_code_in = blank_code_ff;
      minus_code_in = minus_code_ff;
      cell_ctrl     = '0;

      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_BLANK_CODE: blank_code_in = csr_data;
            CSR_MINUS_CODE: minus_code_in = csr_data;
            default:        blank_code_in = blank_code_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               shift_in        = magnitude;
               negative_in     = req_value[ValueWidth-1];
               dot_enable_in   = req_dot_enable;
               dot_places_in   = req_dot_places;
               count_in        = '0;
               emit_done_in    = 1'b0;
               dot_digit_in    = '0;
               cell_ctrl.clear = 1'b1;
               state_in        = ST_CONV;
            end
         end
         ST_CONV: begin
            cell_ctrl.convert = 1'b1;
            shift_in          = shift_ff << 1;
            count_in          = count_ff + CountWidth'(1);
            if (count_ff == CountWidth'(ValueWidth - 1)) begin
               pos_in   = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cell_ctrl.drain = 1'b1;
            rsp_valid_in    = 1'b1;
            rsp_addr_in     = AddrWidth'(pos_ff) + AddrWidth'(1);
            rsp_data_in     = blank_now ? blank_code_ff : DataWidth'(low_digit);
            if (AddrWidth'(pos_ff) == AddrWidth'(dot_places_ff)) begin
               dot_digit_in = low_digit;
            end
            pos_in       = pos_ff + PosWidth'(1);
            emit_done_in = final_pos;
            rsp_last_in  = final_pos && !minus_now && !dot_on;
            priority if (minus_now) begin
               state_in = ST_MINUS;
            end else if (final_pos) begin
               state_in = dot_on ? ST_DOT : ST_IDLE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_MINUS: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = minus_code_ff;
            negative_in  = 1'b0;
            rsp_last_in  = emit_done_ff && !dot_on;
            if (emit_done_ff) begin
               state_in = dot_on ? ST_DOT : ST_IDLE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_DOT: begin
            rsp_valid_in = 1'b1;
            rsp_addr_in  = AddrWidth'(dot_places_ff) + AddrWidth'(1);
            rsp_data_in  = DataWidth'(dot_digit_ff) | point_mask;
            rsp_last_in  = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         rsp_last_ff   <= 1'b0;
         blank_code_ff <= BlankReset;
         minus_code_ff <= MinusReset;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_last_ff   <= rsp_last_in;
         blank_code_ff <= blank_code_in;
         minus_code_ff <= minus_code_in;
      end
      shift_ff      <= shift_in;
      negative_ff   <= negative_in;
      dot_enable_ff <= dot_enable_in;
      dot_places_ff <= dot_places_in;
      count_ff      <= count_in;
      pos_ff        <= pos_in;
      emit_done_ff  <= emit_done_in;
      dot_digit_ff  <= dot_digit_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign csr_ready            = 1'b1;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_register_address = rsp_addr_ff;
   assign rsp_register_data    = rsp_data_ff;
   assign rsp_last             = rsp_last_ff;

`ifndef SYNTHESIS
   a_no_chain_overflow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV) |-> !chain_overflow)
      else $error("bcd chain carried out of its top cell");

   a_word_needs_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("word shown without an item in work");

   a_last_is_word: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_valid)
      else $error("last flag without a word");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !rsp_valid)
      else $error("word shown right after the last word");

   a_address_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_register_address != '0 &&
                     rsp_register_address <= AddrWidth'(DigitCount)))
      else $error("digit address out of range");
`endif

endmodule

// File: rtl/sdf_bcd_cell.sv
module sdf_bcd_cell (
   input  logic                          clock,
   input  sdf_pkg::cell_ctrl_type        ctrl,
   input  logic                          carry_in,
   input  logic [sdf_pkg::BcdWidth-1:0]  upper_digit,
   output logic                          carry_out,
   output logic [sdf_pkg::BcdWidth-1:0]  digit
);
   import sdf_pkg::*;

   logic [BcdWidth-1:0] digit_ff;
   logic [BcdWidth-1:0] digit_in;
   logic [BcdWidth-1:0] adjusted;

   always_comb begin
      adjusted = (digit_ff >= BcdWidth'(5)) ? digit_ff + BcdWidth'(3) : digit_ff;
      priority if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.convert) begin
         digit_in = {adjusted[BcdWidth-2:0], carry_in};
      end else if (ctrl.drain) begin
         digit_in = upper_digit;
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign carry_out = adjusted[BcdWidth-1];
   assign digit     = digit_ff;

endmodule

// File: rtl/sdf_bcd_chain.sv
module sdf_bcd_chain (
   input  logic                          clock,
   input  sdf_pkg::cell_ctrl_type        ctrl,
   input  logic                          serial_in,
   output logic [sdf_pkg::BcdWidth-1:0]  low_digit,
   output logic                          all_zero,
   output logic                          overflow
);
   import sdf_pkg::*;

   logic [BcdWidth-1:0] digits  [CellCount];
   logic [CellCount:0]  carries;
   logic [CellCount-1:0] nonzero;

   assign carries[0] = serial_in;

   for (genvar i = 0; i < CellCount; i++) begin : g_cell
      logic [BcdWidth-1:0] upper;
      if (i == CellCount - 1) begin : g_top
         assign upper = '0;
      end else begin : g_mid
         assign upper = digits[i+1];
      end
      sdf_bcd_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .carry_in    (carries[i]),
         .upper_digit (upper),
         .carry_out   (carries[i+1]),
         .digit       (digits[i])
      );
      assign nonzero[i] = |digits[i];
   end

   assign low_digit = digits[0];
   assign all_zero  = ~|nonzero;
   assign overflow  = carries[CellCount];

endmodule

// File: tb/sv/sdf_frame_checker.sv
`timescale 1ns / 100ps

module sdf_frame_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  busy,
   input  logic [sdf_pkg::ValueWidth-1:0]        req_value,
   input  logic                                  req_dot_enable,
   input  logic [2:0]                            req_dot_places,
   input  logic                                  rsp_valid,
   input  logic [sdf_pkg::AddrWidth-1:0]         rsp_register_address,
   input  logic [sdf_pkg::DataWidth-1:0]         rsp_register_data,
   input  logic                                  rsp_last,
   input  logic                                  csr_valid,
   input  logic                                  csr_ready,
   input  logic                                  csr_index,
   input  logic [sdf_pkg::DataWidth-1:0]         csr_data,
   output int                                    mismatch_count,
   output int                                    words_pending
);
   import sdf_pkg::*;

   typedef struct packed {
      logic [AddrWidth-1:0] address;
      logic [DataWidth-1:0] data;
      logic                 last;
   } digit_word_type;

   logic [DataWidth-1:0] blank_code;
   logic [DataWidth-1:0] minus_code;
   digit_word_type       display_words[$];
   digit_word_type       wanted;

   function automatic void append_word(input int unsigned position,
                                       input logic [DataWidth-1:0] code);
      digit_word_type word;
      word.address = AddrWidth'(position + 1);
      word.data    = code;
      word.last    = 1'b0;
      display_words.push_back(word);
   endfunction

   function automatic void predict_display(input logic [ValueWidth-1:0] raw,
                                           input logic dot_on,
                                           input logic [2:0] dot_pos);
      logic [ValueWidth-1:0] magnitude;
      logic [ValueWidth-1:0] remaining;
      logic [ValueWidth-1:0] shifted;
      logic [DataWidth-1:0]  point_code;
      logic                  blanking;
      logic                  minus_due;
      digit_word_type        tail;
      magnitude = raw[ValueWidth-1] ? ValueWidth'(-raw) : raw;
      remaining = magnitude;
      blanking  = 1'b0;
      minus_due = raw[ValueWidth-1];
      for (int pos = 0; pos < DigitCount; pos++) begin
         if (blanking) begin
            append_word(pos, blank_code);
            if (minus_due) begin
               append_word(pos, minus_code);
               minus_due = 1'b0;
            end
         end else begin
            append_word(pos, DataWidth'(remaining % 10));
            remaining = remaining / 10;
            if (remaining == 0) blanking = 1'b1;
         end
      end
      if (dot_on && dot_pos < DigitCount) begin
         shifted = magnitude;
         repeat (dot_pos) shifted = shifted / 10;
         point_code           = DataWidth'(shifted % 10);
         point_code[PointBit] = 1'b1;
         append_word(dot_pos, point_code);
      end
      tail = display_words.pop_back();
      tail.last = 1'b1;
      display_words.push_back(tail);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         blank_code     = BlankReset;
         minus_code     = MinusReset;
         mismatch_count = 0;
         display_words.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_BLANK_CODE: blank_code = csr_data;
               CSR_MINUS_CODE: minus_code = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (display_words.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected word addr %0d data %02h last %b", $realtime,
                           rsp_register_address, rsp_register_data, rsp_last);
            end else begin
               wanted = display_words.pop_front();
               if (rsp_register_address !== wanted.address ||
                   rsp_register_data !== wanted.data || rsp_last !== wanted.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: word mismatch addr %0d/%0d data %02h/%02h last %b/%b",
                              $realtime, wanted.address, rsp_register_address,
                              wanted.data, rsp_register_data, wanted.last, rsp_last);
               end
            end
         end
         if (start && !busy) predict_display(req_value, req_dot_enable, req_dot_places);
      end
      words_pending = display_words.size();
   end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import sdf_pkg::*;

   localparam int IdleLimit   = 1000;
   localparam int SettleDelay = 48;
   localparam int PhaseItems  = 61;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  start          = 1'b0;
   logic                  busy;
   logic [ValueWidth-1:0] req_value      = '0;
   logic                  req_dot_enable = 1'b0;
   logic [2:0]            req_dot_places = '0;
   logic                  rsp_valid;
   logic [AddrWidth-1:0]  rsp_register_address;
   logic [DataWidth-1:0]  rsp_register_data;
   logic                  rsp_last;
   logic                  csr_valid      = 1'b0;
   logic                  csr_ready;
   logic                  csr_index      = CSR_BLANK_CODE;
   logic [DataWidth-1:0]  csr_data       = '0;
   int                    mismatch_count;
   int                    words_pending;
   int                    idle_cycles    = 0;
   int                    calm_left      = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   signed_decimal_digit_frame_formatter i_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_value            (req_value),
      .req_dot_enable       (req_dot_enable),
      .req_dot_places       (req_dot_places),
      .rsp_valid            (rsp_valid),
      .rsp_register_address (rsp_register_address),
      .rsp_register_data    (rsp_register_data),
      .rsp_last             (rsp_last),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   sdf_frame_checker i_checker (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_value            (req_value),
      .req_dot_enable       (req_dot_enable),
      .req_dot_places       (req_dot_places),
      .rsp_valid            (rsp_valid),
      .rsp_register_address (rsp_register_address),
      .rsp_register_data    (rsp_register_data),
      .rsp_last             (rsp_last),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .mismatch_count       (mismatch_count),
      .words_pending        (words_pending)
   );

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_value(input logic [ValueWidth-1:0] value, input logic dot_on,
                             input logic [2:0] dot_pos);
      int unsigned gap;
      logic        calm;
      gap  = $urandom_range(0, 18);
      calm = 1'b0;
      if (calm_left > 0) begin
         calm_left--;
         calm = 1'b1;
      end else if ($urandom_range(0, 15) == 0) begin
         calm_left = $urandom_range(5, 15);
         calm = 1'b1;
      end
      if (!calm) begin
         if ($urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            do @(posedge clock); while (busy);
            repeat (gap) @(posedge clock);
         end else if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      start          <= 1'b1;
      req_value      <= value;
      req_dot_enable <= dot_on;
      req_dot_places <= dot_pos;
      do @(posedge clock); while (busy);
   endtask

   task automatic write_codes(input logic [DataWidth-1:0] blank,
                              input logic [DataWidth-1:0] minus);
      csr_valid <= 1'b1;
      csr_index <= CSR_BLANK_CODE;
      csr_data  <= blank;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_MINUS_CODE;
      csr_data  <= minus;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic drain_display();
      start <= 1'b0;
      @(posedge clock);
      wait (words_pending == 0);
      repeat (SettleDelay) @(posedge clock);
   endtask

   function automatic logic [ValueWidth-1:0] pick_value();
      logic [ValueWidth-1:0] magnitude;
      int unsigned           flavor;
      int unsigned           limit;
      flavor = $urandom_range(0, 9);
      if (flavor < 6) begin
         limit = 1;
         repeat ($urandom_range(1, 9)) limit = limit * 10;
         magnitude = $urandom_range(0, limit - 1);
         return $urandom_range(0, 1) ? ValueWidth'(-magnitude) : magnitude;
      end else if (flavor < 9) begin
         return $urandom;
      end
      case ($urandom_range(0, 3))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '0;
         default: return ValueWidth'(-32'd9_999_999);
      endcase
   endfunction

   task automatic send_random(input int count);
      repeat (count) send_value(pick_value(), 1'($urandom_range(0, 1)),
                                3'($urandom_range(0, 7)));
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_value(32'd0, 1'b1, 3'd0);
      send_value(32'd1, 1'b0, 3'd0);
      send_value(-32'd1, 1'b0, 3'd0);
      send_value(32'd9, 1'b0, 3'd5);
      send_value(-32'd9, 1'b1, 3'd1);
      send_value(32'd10, 1'b1, 3'd1);
      send_value(-32'd10, 1'b0, 3'd0);
      send_value(-32'd5, 1'b1, 3'd2);
      send_value(32'd5, 1'b1, 3'd7);
      send_value(32'd42, 1'b0, 3'd7);
      send_value(32'd1234567, 1'b1, 3'd7);
      send_value(-32'd1234567, 1'b0, 3'd0);
      send_value(-32'd9999999, 1'b1, 3'd7);
      send_value(32'd10000000, 1'b1, 3'd6);
      send_value(-32'd10000000, 1'b0, 3'd0);
      send_value(32'd12345678, 1'b1, 3'd4);
      send_value(-32'd12345678, 1'b0, 3'd0);
      send_value(32'd99999999, 1'b1, 3'd7);
      send_value(32'd100000000, 1'b0, 3'd0);
      send_value(-32'd100000000, 1'b1, 3'd3);
      send_value(32'd10203040, 1'b1, 3'd3);
      send_value(32'h7fff_ffff, 1'b1, 3'd7);
      send_value(32'h8000_0000, 1'b1, 3'd0);
      send_value(32'hffff_ffff, 1'b1, 3'd5);
      drain_display();

      write_codes(8'h00, 8'hff);
      send_value(-32'd7, 1'b1, 3'd1);
      send_value(32'd0, 1'b0, 3'd0);
      send_random(PhaseItems);
      drain_display();

      write_codes(8'hff, 8'h00);
      send_value(-32'd7, 1'b1, 3'd6);
      send_random(PhaseItems);
      drain_display();

      write_codes(DataWidth'($urandom_range(0, 255)), DataWidth'($urandom_range(0, 255)));
      send_random(PhaseItems);
      drain_display();

      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
